// ===== hw/rtl/spatial_grid_cell_binning_macros.svh =====
// Assertion macros for the grid cell binning checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef SPATIAL_GRID_CELL_BINNING_MACROS_SVH
`define SPATIAL_GRID_CELL_BINNING_MACROS_SVH

// Plain property, sampled on the rising clock, off while reset is held
`define SGCB_ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");

// Same-cycle implication
`define SGCB_ASSERT_IMPLIES(lbl, ante, cons) \
  `SGCB_ASSERT_PROP(lbl, (ante) |-> (cons))

// Next-cycle implication
`define SGCB_ASSERT_NEXT(lbl, ante, cons) \
  `SGCB_ASSERT_PROP(lbl, (ante) |=> (cons))

`endif

// ===== hw/rtl/sgcb_pkg.sv =====
// Shared constants, codes and types for the grid cell binning block.
// No dependencies; used by the cell mapper, the top level and the checker.
`default_nettype none

package sgcb_pkg;

  // Grid and storage sizing
  localparam int unsigned MaxCells     = 4096;
  localparam int unsigned CellW        = $clog2(MaxCells);
  localparam int unsigned CountW       = CellW + 1;
  localparam int unsigned SlotsPerCell = 16;
  localparam int unsigned SlotW        = $clog2(SlotsPerCell);
  localparam int unsigned FillW        = SlotW + 1;
  localparam int unsigned CoordW       = 16;
  localparam int unsigned ItemW        = 12;

  // Config register widths
  localparam int unsigned GridDimW = 7;
  localparam int unsigned ShiftW   = 4;
  localparam int unsigned CfgIdxW  = 2;

  // Config register indexes
  localparam logic [CfgIdxW-1:0] CfgGridColumns = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGridRows    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCellSizeLog = 2'd2;

  // Config reset values
  localparam logic [GridDimW-1:0] GridColumnsRst = 7'd64;
  localparam logic [GridDimW-1:0] GridRowsRst    = 7'd64;
  localparam logic [ShiftW-1:0]   CellSizeRst    = 4'd8;

  // Op codes (input tuser)
  localparam logic OpFrame  = 1'b0;
  localparam logic OpInsert = 1'b1;

  // Result status codes
  localparam int unsigned StatusW = 2;
  localparam logic [StatusW-1:0] StatusStored  = 2'd0;
  localparam logic [StatusW-1:0] StatusFull    = 2'd1;
  localparam logic [StatusW-1:0] StatusOffGrid = 2'd2;

  // Input word layout: pos_x, pos_y, item_index, padded to bytes
  localparam int unsigned InPosXLsb = 0;
  localparam int unsigned InPosYLsb = InPosXLsb + CoordW;
  localparam int unsigned InItemLsb = InPosYLsb + CoordW;
  localparam int unsigned InUsedW   = InItemLsb + ItemW;
  localparam int unsigned InDataW   = ((InUsedW + 7) / 8) * 8;

  // Output word layout: cell_index, slot, status, first_in_cell, active_count
  localparam int unsigned OutCellLsb  = 0;
  localparam int unsigned OutSlotLsb  = OutCellLsb + CellW;
  localparam int unsigned OutStatLsb  = OutSlotLsb + SlotW;
  localparam int unsigned OutFirstLsb = OutStatLsb + StatusW;
  localparam int unsigned OutCountLsb = OutFirstLsb + 1;
  localparam int unsigned OutUsedW    = OutCountLsb + CountW;
  localparam int unsigned OutDataW    = ((OutUsedW + 7) / 8) * 8;

  // Cell mapper result
  typedef struct packed {
    logic             off_grid;
    logic [CellW-1:0] cell_idx;
  } cell_map_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sgcb_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// Standalone; instantiated by the top level for fill counts and active list.
`default_nettype none

module sgcb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  parameter int unsigned Aw    = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sgcb_cell_map.sv =====
// Position to cell mapper: captures shifted coordinates, forms row-major index.
// Depends on sgcb_pkg.
`default_nettype none

module sgcb_cell_map (
  input  wire logic                            clk_i,
  input  wire logic                            load_i,
  input  wire logic [sgcb_pkg::CoordW-1:0]     pos_x_i,
  input  wire logic [sgcb_pkg::CoordW-1:0]     pos_y_i,
  input  wire logic [sgcb_pkg::GridDimW-1:0]   grid_columns_i,
  input  wire logic [sgcb_pkg::GridDimW-1:0]   grid_rows_i,
  input  wire logic [sgcb_pkg::ShiftW-1:0]     cell_size_log2_i,
  output sgcb_pkg::cell_map_t                  map_o
);

  localparam int unsigned ProdW = sgcb_pkg::CoordW + sgcb_pkg::GridDimW;
  localparam int unsigned SumW  = ProdW + 1;

  logic [sgcb_pkg::CoordW-1:0] col_q, row_q;
  logic [ProdW-1:0]            prod;
  logic [SumW-1:0]             sum;

  // Coordinates drop to cell units at capture (truncating shift)
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      col_q <= pos_x_i >> cell_size_log2_i;
      row_q <= pos_y_i >> cell_size_log2_i;
    end
  end

  assign prod = row_q * grid_columns_i;
  assign sum  = {{(SumW - sgcb_pkg::CoordW){1'b0}}, col_q} + {1'b0, prod};

  assign map_o.off_grid =
      (col_q >= {{(sgcb_pkg::CoordW - sgcb_pkg::GridDimW){1'b0}}, grid_columns_i}) ||
      (row_q >= {{(sgcb_pkg::CoordW - sgcb_pkg::GridDimW){1'b0}}, grid_rows_i}) ||
      (sum >= SumW'(sgcb_pkg::MaxCells));
  assign map_o.cell_idx = sum[sgcb_pkg::CellW-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/spatial_grid_cell_binning.sv =====
// Top level of the uniform 2D grid cell binning block.
// Depends on sgcb_pkg, sgcb_ram and sgcb_cell_map.
`default_nettype none

// Bins items into a row-major grid of up to 4096 cells. An insert word (tuser = 1)
// maps pos_x/pos_y to a cell by a right shift of cell_size_log2, bumps that cell's
// fill count and returns cell, slot, status and whether the cell just became active;
// a frame word (tuser = 0) empties every cell activated since the last frame.
// Per-cell fill counts live in a 4096 x 5 RAM; the order of activation lives in a
// 4096 x 12 active-list RAM. An insert steps through capture, map plus fill read,
// then update plus write back, which waits while the output register is full;
// the block then returns to idle for the next word. A frame walks the active
// list, one list read per cycle, each followed by a fill write of zero, then
// sends its result from the update state, which also waits for the output register.
// After reset the block sweeps all 4096 fill RAM entries to zero, holding
// s_axis_tready low; config writes are taken at any time. Config must only be
// written while no word is in flight. Item member lists are not kept here; the
// item_index field is carried in the input word but not stored. One result word
// is held in an output register so a new input word can be taken while it waits.
module spatial_grid_cell_binning (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Input stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [15:0] pos_x, [31:16] pos_y, [43:32] item_index, [47:44] zero
  input  wire logic [sgcb_pkg::InDataW-1:0]    s_axis_tdata,
  // [0] op
  input  wire logic [0:0]                      s_axis_tuser,
  // Result stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [11:0] cell_index, [15:12] slot, [17:16] status, [18] first_in_cell,
  // [31:19] active_count
  output logic [sgcb_pkg::OutDataW-1:0]        m_axis_tdata,
  // Config write channel
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [sgcb_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [sgcb_pkg::GridDimW-1:0]   cfg_data_i
);

  localparam int unsigned CellW  = sgcb_pkg::CellW;
  localparam int unsigned CountW = sgcb_pkg::CountW;
  localparam int unsigned FillW  = sgcb_pkg::FillW;
  localparam int unsigned SlotW  = sgcb_pkg::SlotW;

  // Sequencer states
  localparam logic [2:0] StInit = 3'd0;  // post-reset fill RAM sweep
  localparam logic [2:0] StIdle = 3'd1;  // waiting for a word
  localparam logic [2:0] StMap  = 3'd2;  // cell index ready, fill read issued
  localparam logic [2:0] StClr  = 3'd3;  // walking the active list
  localparam logic [2:0] StUpd  = 3'd4;  // result out, write back

  logic [2:0] state_q, state_d;

  // Config registers
  logic [sgcb_pkg::GridDimW-1:0] grid_columns_q, grid_rows_q;
  logic [sgcb_pkg::ShiftW-1:0]   cell_size_log2_q;

  // Working registers
  logic              op_q, op_d;
  logic              off_q, off_d;
  logic [CellW-1:0]  cell_q, cell_d;
  logic [CountW-1:0] total_q, total_d;
  logic [CountW-1:0] idx_q, idx_d;    // sweep and list walk pointer
  logic              pend_q, pend_d;  // list read in flight during clear

  // Output register
  logic                          out_valid_q, out_valid_d;
  logic [sgcb_pkg::OutDataW-1:0] out_data_q, out_data_d;

  logic s_fire, out_free;

  sgcb_pkg::cell_map_t map;

  // RAM ports
  logic             fill_we, fill_re;
  logic [CellW-1:0] fill_waddr, fill_raddr;
  logic [FillW-1:0] fill_wdata, fill_rdata;
  logic             list_we, list_re;
  logic [CellW-1:0] list_waddr, list_raddr;
  logic [CellW-1:0] list_wdata, list_rdata;

  // Result fields
  logic [CellW-1:0]              res_cell;
  logic [SlotW-1:0]              res_slot;
  logic [sgcb_pkg::StatusW-1:0]  res_status;
  logic                          res_first;
  logic [CountW-1:0]             res_count;

  assign s_axis_tready = (state_q == StIdle);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign cfg_ready_o   = 1'b1;

  // Config writes; an index past the list is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_columns_q   <= sgcb_pkg::GridColumnsRst;
      grid_rows_q      <= sgcb_pkg::GridRowsRst;
      cell_size_log2_q <= sgcb_pkg::CellSizeRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sgcb_pkg::CfgGridColumns: grid_columns_q   <= cfg_data_i;
        sgcb_pkg::CfgGridRows:    grid_rows_q      <= cfg_data_i;
        sgcb_pkg::CfgCellSizeLog: cell_size_log2_q <= cfg_data_i[sgcb_pkg::ShiftW-1:0];
        default: ;
      endcase
    end
  end

  sgcb_cell_map u_cell_map (
    .clk_i            (clk_i),
    .load_i           (s_fire),
    .pos_x_i          (s_axis_tdata[sgcb_pkg::InPosXLsb +: sgcb_pkg::CoordW]),
    .pos_y_i          (s_axis_tdata[sgcb_pkg::InPosYLsb +: sgcb_pkg::CoordW]),
    .grid_columns_i   (grid_columns_q),
    .grid_rows_i      (grid_rows_q),
    .cell_size_log2_i (cell_size_log2_q),
    .map_o            (map)
  );

  sgcb_ram #(
    .Width (FillW),
    .Depth (sgcb_pkg::MaxCells)
  ) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (fill_waddr),
    .wdata_i (fill_wdata),
    .re_i    (fill_re),
    .raddr_i (fill_raddr),
    .rdata_o (fill_rdata)
  );

  sgcb_ram #(
    .Width (CellW),
    .Depth (sgcb_pkg::MaxCells)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (list_we),
    .waddr_i (list_waddr),
    .wdata_i (list_wdata),
    .re_i    (list_re),
    .raddr_i (list_raddr),
    .rdata_o (list_rdata)
  );

  // Result of the item in StUpd. A cell is active exactly when its fill is
  // non-zero, so no separate mark is stored.
  always_comb begin
    res_cell   = '0;
    res_slot   = '0;
    res_status = sgcb_pkg::StatusStored;
    res_first  = 1'b0;
    res_count  = total_q;
    if (op_q == sgcb_pkg::OpFrame) begin
      res_count = '0;
    end else if (off_q) begin
      res_status = sgcb_pkg::StatusOffGrid;
    end else if (fill_rdata >= FillW'(sgcb_pkg::SlotsPerCell)) begin
      res_status = sgcb_pkg::StatusFull;
      res_cell   = cell_q;
    end else begin
      res_cell  = cell_q;
      res_slot  = fill_rdata[SlotW-1:0];
      res_first = (fill_rdata == '0);
      if (res_first && (total_q < CountW'(sgcb_pkg::MaxCells))) begin
        res_count = total_q + CountW'(1);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    off_d       = off_q;
    cell_d      = cell_q;
    total_d     = total_q;
    idx_d       = idx_q;
    pend_d      = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;

    fill_we    = 1'b0;
    fill_waddr = cell_q;
    fill_wdata = '0;
    fill_re    = 1'b0;
    fill_raddr = map.cell_idx;
    list_we    = 1'b0;
    list_waddr = total_q[CellW-1:0];
    list_wdata = cell_q;
    list_re    = 1'b0;
    list_raddr = idx_q[CellW-1:0];

    case (state_q)
      StInit: begin
        fill_we    = 1'b1;
        fill_waddr = idx_q[CellW-1:0];
        idx_d      = idx_q + CountW'(1);
        if (idx_q[CellW-1:0] == CellW'(sgcb_pkg::MaxCells - 1)) begin
          idx_d   = '0;
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (s_fire) begin
          op_d = s_axis_tuser[0];
          if (s_axis_tuser[0] == sgcb_pkg::OpInsert) begin
            state_d = StMap;
          end else begin
            idx_d   = '0;
            state_d = StClr;
          end
        end
      end
      StMap: begin
        off_d   = map.off_grid;
        cell_d  = map.cell_idx;
        fill_re = !map.off_grid;
        state_d = StUpd;
      end
      StClr: begin
        // Read list entry idx, zero that cell's fill in the next cycle
        if (idx_q != total_q) begin
          list_re = 1'b1;
          idx_d   = idx_q + CountW'(1);
          pend_d  = 1'b1;
        end
        if (pend_q) begin
          fill_we    = 1'b1;
          fill_waddr = list_rdata;
        end
        if ((idx_q == total_q) && !pend_q) begin
          state_d = StUpd;
        end
      end
      StUpd: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          out_data_d[sgcb_pkg::OutCellLsb +: CellW]              = res_cell;
          out_data_d[sgcb_pkg::OutSlotLsb +: SlotW]              = res_slot;
          out_data_d[sgcb_pkg::OutStatLsb +: sgcb_pkg::StatusW]  = res_status;
          out_data_d[sgcb_pkg::OutFirstLsb]                      = res_first;
          out_data_d[sgcb_pkg::OutCountLsb +: CountW]            = res_count;
          total_d = res_count;
          if (op_q == sgcb_pkg::OpInsert && !off_q &&
              res_status == sgcb_pkg::StatusStored) begin
            fill_we    = 1'b1;
            fill_wdata = fill_rdata + FillW'(1);
            list_we    = res_first && (total_q < CountW'(sgcb_pkg::MaxCells));
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StInit;
      total_q     <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    off_q      <= off_d;
    cell_q     <= cell_d;
    out_data_q <= out_data_d;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sgcb_checker.sv =====
// Port-level checker for the grid cell binning block, bound to the top level.
// Depends on sgcb_pkg and spatial_grid_cell_binning_macros.svh.
`default_nettype none

`include "spatial_grid_cell_binning_macros.svh"

module sgcb_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [sgcb_pkg::OutDataW-1:0] m_axis_tdata
);

  logic [sgcb_pkg::StatusW-1:0] status;
  logic [sgcb_pkg::SlotW-1:0]   slot;
  logic [sgcb_pkg::CellW-1:0]   cell_idx;
  logic                         first;

  assign status   = m_axis_tdata[sgcb_pkg::OutStatLsb +: sgcb_pkg::StatusW];
  assign slot     = m_axis_tdata[sgcb_pkg::OutSlotLsb +: sgcb_pkg::SlotW];
  assign cell_idx = m_axis_tdata[sgcb_pkg::OutCellLsb +: sgcb_pkg::CellW];
  assign first    = m_axis_tdata[sgcb_pkg::OutFirstLsb];

  // A held result keeps its word
  `SGCB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // One word in flight: ready drops right after an accept
  `SGCB_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // Only the three defined status codes appear
  `SGCB_ASSERT_IMPLIES(a_status_code, m_axis_tvalid, status == sgcb_pkg::StatusStored || status == sgcb_pkg::StatusFull || status == sgcb_pkg::StatusOffGrid)

  // A newly active cell was empty, so the item is stored in slot zero
  `SGCB_ASSERT_IMPLIES(a_first_slot0, m_axis_tvalid && first, status == sgcb_pkg::StatusStored && slot == '0)

  // Off-grid results carry no cell, slot or activation
  `SGCB_ASSERT_IMPLIES(a_offgrid_clean, m_axis_tvalid && status == sgcb_pkg::StatusOffGrid, cell_idx == '0 && slot == '0 && !first)

endmodule

bind spatial_grid_cell_binning sgcb_checker u_sgcb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
